FILE: design/jsu_pkg.sv
package jsu_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    ST_BUSY     = 3'd0,
    ST_DONE     = 3'd1,
    ST_NO_QUOTE = 3'd2,
    ST_BAD_ESC  = 3'd3,
    ST_BAD_HEX  = 3'd4,
    ST_BAD_SURR = 3'd5,
    ST_UNTERM   = 3'd6
  } status_t;

  // n = 0 marks a step that yields a single result with no byte
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      n;
    status_t         st;
  } entry_t;

endpackage

FILE: design/jsu_in_if.sv
interface jsu_in_if;
  import jsu_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       text_end;

  modport source (output valid, output text_byte, output text_end, input ready);
  modport sink (input valid, input text_byte, input text_end, output ready);
endinterface

FILE: design/jsu_out_if.sv
interface jsu_out_if;
  import jsu_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] utf8_byte;
  logic       byte_valid;
  logic [2:0] status;
  logic       last_result;

  modport source (output valid, output utf8_byte, output byte_valid, output status,
                  output last_result, input ready);
  modport sink (input valid, input utf8_byte, input byte_valid, input status,
                input last_result, output ready);
endinterface

FILE: design/jsu_front.sv
module jsu_front import jsu_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  jsu_in_if.sink in_ch,
  input  logic   full,
  output logic   push,
  output entry_t push_data
);

  typedef enum logic [6:0] {
    M_IDLE    = 7'b0000001,
    M_BODY    = 7'b0000010,
    M_ESC     = 7'b0000100,
    M_HEX1    = 7'b0001000,
    M_PAIR_BS = 7'b0010000,
    M_PAIR_U  = 7'b0100000,
    M_HEX2    = 7'b1000000
  } mode_t;

  mode_t       mode, mode_next;
  logic [15:0] hex_accum, hex_accum_next;
  logic [9:0]  high_half, high_half_next;
  logic [1:0]  hex_count, hex_count_next;

  logic [7:0]  b;
  logic        hex_ok;
  logic [3:0]  hex_digit;
  logic [15:0] hex_new;
  logic [20:0] pair_cp;
  entry_t      ent;

  function automatic entry_t utf8_enc(input logic [20:0] cp);
    entry_t e;
    e = '0;
    if (cp < 21'h80) begin
      e.bytes[0] = cp[7:0];
      e.n        = 3'd1;
    end else if (cp < 21'h800) begin
      e.bytes[0] = 8'hC0 | {3'b000, cp[10:6]};
      e.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
      e.n        = 3'd2;
    end else if (cp < 21'h10000) begin
      e.bytes[0] = 8'hE0 | {4'b0000, cp[15:12]};
      e.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
      e.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
      e.n        = 3'd3;
    end else begin
      e.bytes[0] = 8'hF0 | {5'b00000, cp[20:18]};
      e.bytes[1] = 8'h80 | {2'b00, cp[17:12]};
      e.bytes[2] = 8'h80 | {2'b00, cp[11:6]};
      e.bytes[3] = 8'h80 | {2'b00, cp[5:0]};
      e.n        = 3'd4;
    end
    return e;
  endfunction

  assign b           = in_ch.text_byte;
  assign in_ch.ready = !full;
  assign push        = in_ch.valid && !full;
  assign push_data   = ent;

  always_comb begin
    hex_ok    = 1'b1;
    hex_digit = 4'd0;
    if (b inside {["0":"9"]}) begin
      hex_digit = 4'(b - 8'h30);
    end else if (b inside {["a":"f"]}) begin
      hex_digit = 4'(b - 8'h57);
    end else if (b inside {["A":"F"]}) begin
      hex_digit = 4'(b - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign hex_new = {hex_accum[11:0], hex_digit};
  assign pair_cp = 21'h10000 + {1'b0, high_half, hex_new[9:0]};

  always_comb begin
    mode_next      = mode;
    hex_accum_next = hex_accum;
    high_half_next = high_half;
    hex_count_next = hex_count;
    ent            = '0;
    ent.st         = ST_BUSY;

    case (mode)
      M_BODY: begin
        if (b == "\"") begin
          ent.st = ST_DONE;
        end else if (b == "\\") begin
          mode_next = M_ESC;
        end else begin
          ent.bytes[0] = b;
          ent.n        = 3'd1;
        end
      end
      M_ESC: begin
        mode_next = M_BODY;
        ent.n     = 3'd1;
        case (b)
          "\"": ent.bytes[0] = 8'h22;
          "\\": ent.bytes[0] = 8'h5C;
          "/":  ent.bytes[0] = 8'h2F;
          "b":  ent.bytes[0] = 8'h08;
          "f":  ent.bytes[0] = 8'h0C;
          "n":  ent.bytes[0] = 8'h0A;
          "r":  ent.bytes[0] = 8'h0D;
          "t":  ent.bytes[0] = 8'h09;
          "u": begin
            ent.n          = 3'd0;
            mode_next      = M_HEX1;
            hex_accum_next = '0;
            hex_count_next = '0;
          end
          default: begin
            ent.n     = 3'd0;
            mode_next = M_ESC;
            ent.st    = ST_BAD_ESC;
          end
        endcase
      end
      M_HEX1, M_HEX2: begin
        if (!hex_ok) begin
          ent.st = ST_BAD_HEX;
        end else if (hex_count != 2'd3) begin
          hex_accum_next = hex_new;
          hex_count_next = hex_count + 2'd1;
        end else begin
          hex_accum_next = '0;
          hex_count_next = '0;
          if (mode == M_HEX1) begin
            if (hex_new >= 16'hD800 && hex_new <= 16'hDBFF) begin
              high_half_next = hex_new[9:0];
              mode_next      = M_PAIR_BS;
            end else if (hex_new >= 16'hDC00 && hex_new <= 16'hDFFF) begin
              ent.st = ST_BAD_SURR;
            end else begin
              ent       = utf8_enc({5'd0, hex_new});
              mode_next = M_BODY;
            end
          end else begin
            if (hex_new >= 16'hDC00 && hex_new <= 16'hDFFF) begin
              ent       = utf8_enc(pair_cp);
              mode_next = M_BODY;
            end else begin
              ent.st = ST_BAD_SURR;
            end
          end
        end
      end
      M_PAIR_BS: begin
        if (b == "\\") begin
          mode_next = M_PAIR_U;
        end else begin
          ent.st = ST_BAD_SURR;
        end
      end
      M_PAIR_U: begin
        if (b == "u") begin
          mode_next      = M_HEX2;
          hex_accum_next = '0;
          hex_count_next = '0;
        end else begin
          ent.st = ST_BAD_SURR;
        end
      end
      default: begin
        mode_next = M_IDLE;
        if (b == " " || b == 8'h09 || b == 8'h0A || b == 8'h0D) begin
          if (in_ch.text_end) begin
            ent.st = ST_NO_QUOTE;
          end
        end else if (b == "\"") begin
          mode_next = M_BODY;
        end else begin
          ent.st = ST_NO_QUOTE;
        end
      end
    endcase

    if (ent.st == ST_BUSY && in_ch.text_end && mode_next != M_IDLE) begin
      ent.st = ST_UNTERM;
    end
    if (ent.st != ST_BUSY) begin
      mode_next      = M_IDLE;
      hex_accum_next = '0;
      high_half_next = '0;
      hex_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_IDLE;
      hex_accum <= '0;
      high_half <= '0;
      hex_count <= '0;
    end else if (push) begin
      mode      <= mode_next;
      hex_accum <= hex_accum_next;
      high_half <= high_half_next;
      hex_count <= hex_count_next;
    end
  end

endmodule

FILE: design/jsu_queue.sv
module jsu_queue import jsu_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_data,
  input  logic   pop,
  output logic   full,
  output logic   empty,
  output entry_t head
);

  entry_t              slots [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full  = (count == QCNT_W'(QDEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

FILE: design/jsu_back.sv
module jsu_back import jsu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        empty,
  input  entry_t      head,
  output logic        pop,
  jsu_out_if.source   out_ch
);

  entry_t     cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       last;
  logic       load;

  assign last = (cur.n == 3'd0) || (idx == 2'(cur.n - 3'd1));
  assign load = !cur_valid || (out_ch.valid && out_ch.ready && last);
  assign pop  = load && !empty;

  assign out_ch.valid       = cur_valid;
  assign out_ch.utf8_byte   = cur.bytes[idx];
  assign out_ch.byte_valid  = (cur.n != 3'd0);
  assign out_ch.status      = last ? cur.st : ST_BUSY;
  assign out_ch.last_result = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      cur_valid <= !empty;
      idx       <= '0;
    end else if (out_ch.valid && out_ch.ready) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

endmodule

FILE: design/json_string_unescape_utf8.sv
// JSON string unescaper with UTF-8 output. Accepts one text byte per cycle and
// returns one to four results for it, one result per cycle while out_ch.ready
// is high, in order; the last result of each byte carries last_result and the
// step's status. A four-entry queue between the parser and the output stage
// lets input run at one byte per cycle while multi-byte UTF-8 sequences drain;
// input stalls only when that queue is full. A byte's results are written to a
// queue slot and then registered in the output stage before they appear.
module json_string_unescape_utf8 import jsu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  jsu_in_if.sink    in_ch,
  jsu_out_if.source out_ch
);

  logic   push;
  logic   pop;
  logic   full;
  logic   empty;
  entry_t push_data;
  entry_t head;

  jsu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  jsu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (full),
    .empty     (empty),
    .head      (head)
  );

  jsu_back u_back (
    .clk    (clk),
    .rst    (rst),
    .empty  (empty),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
